// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion macros for the GF(2) basis engine RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/gxb_pkg.sv =====
// ============================================================================
// gxb_pkg
// Types and constants shared by the GF(2) basis engine modules.
// ============================================================================
`timescale 1ns / 1ps

package gxb_pkg;

    localparam int VEC_BITS_DEF = 64;
    localparam int VEC_W        = 64;
    localparam int OPC_W        = 2;
    localparam int WIDTH_W      = 7;
    localparam int PIVOT_W      = 6;
    localparam int RANK_W       = 7;
    localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RST = 7'd64;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TEST   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic need_scan;
        logic scan_end;
        logic out_free;
    } gxb_status_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic idle;
        logic scan;
        logic deliver;
    } gxb_ctrl_t;

endpackage

// ===== rtl/gf2_xor_basis_engine_core.sv =====
// ============================================================================
// gf2_xor_basis_engine_core
// GF(2) linear basis: insert, span test and clear over a stored row basis.
// ============================================================================
// The engine takes one transaction at a time. An insert or test scans the
// active bits from the top down, one bit per clock. The scan ends at bit zero,
// or early when a free pivot is found, and the result then waits in the done
// state until the output register can take it. The engine takes its next
// transaction once that result has been handed off. The bit-serial scan
// is set by the single read port of the row memory and the serial XOR
// dependence from one pivot to the next. A clear, an unused opcode, or any
// item at an active width of zero skips the scan and goes straight to the
// result hand-off. The output register lets a new transaction enter while
// the last result waits. A finished result that finds the output register
// still full is held, and the engine stays busy, until the waiting result is
// taken. The row memory needs no clearing pass after reset: only rows marked
// in the occupancy mask are ever used.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gf2_xor_basis_engine_core
    import gxb_pkg::*;
#(
    parameter int VEC_BITS = VEC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OPC_W-1:0]   opcode,
    input  logic [VEC_W-1:0]   vector_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               in_span,
    output logic               stored,
    output logic [PIVOT_W-1:0] pivot_index,
    output logic [VEC_W-1:0]   residue,
    output logic [RANK_W-1:0]  rank,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data
);

    localparam int AW    = $clog2(VEC_BITS);
    localparam int CNT_W = $clog2(VEC_BITS + 1);
    localparam logic [WIDTH_W-1:0] VEC_BITS_W = WIDTH_W'(VEC_BITS);

    gxb_status_t status;
    gxb_ctrl_t   ctrl;

    logic [WIDTH_W-1:0]  active_width_reg;
    logic [VEC_BITS-1:0] occ_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [OPC_W-1:0]    op_reg;
    logic [VEC_BITS-1:0] v_reg;
    logic [AW-1:0]       bit_reg;
    logic [AW-1:0]       pivot_reg;
    logic                span_reg;
    logic                stored_reg;

    logic                out_valid_reg;
    logic                in_span_reg;
    logic                stored_out_reg;
    logic [PIVOT_W-1:0]  pivot_out_reg;
    logic [VEC_W-1:0]    residue_reg;
    logic [RANK_W-1:0]   rank_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [VEC_BITS-1:0] in_masked;
    logic                in_fire;
    logic                is_reduce_op;
    logic                cur_set;
    logic                cur_occ;
    logic                free_hit;
    logic                row_we;
    logic [AW-1:0]       rd_addr;
    logic [VEC_BITS-1:0] row_data;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg <= ACTIVE_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_width_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    assign w_eff = (active_width_reg > VEC_BITS_W) ? VEC_BITS_W : active_width_reg;

    always_comb
    begin
        for (int i = 0; i < VEC_BITS; i++)
        begin
            in_masked[i] = vector_bits[i] && (WIDTH_W'(i) < w_eff);
        end
    end

    assign in_stall     = !ctrl.idle;
    assign in_fire      = in_valid && !in_stall;
    assign is_reduce_op = (opcode == OP_INSERT) || (opcode == OP_TEST);

    // ------------------------------------------------------------------------
    // Scan step: the row for the current bit was read in the previous cycle.
    // ------------------------------------------------------------------------
    assign cur_set  = v_reg[bit_reg];
    assign cur_occ  = occ_reg[bit_reg];
    assign free_hit = ctrl.scan && cur_set && !cur_occ;
    assign row_we   = free_hit && (op_reg == OP_INSERT);

    always_comb
    begin
        if (ctrl.idle)
        begin
            rd_addr = AW'(w_eff - WIDTH_W'(1));
        end
        else
        begin
            rd_addr = bit_reg - AW'(1);
        end
    end

    assign status.in_fire   = in_fire;
    assign status.need_scan = is_reduce_op && (w_eff != '0);
    assign status.scan_end  = (cur_set && !cur_occ) || (bit_reg == '0);
    assign status.out_free  = !out_valid_reg || !out_stall;

    gxb_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    gxb_row_mem #(
        .DEPTH (VEC_BITS),
        .WIDTH (VEC_BITS)
    ) u_row_mem (
        .clk   (clk),
        .we    (row_we),
        .waddr (bit_reg),
        .wdata (v_reg),
        .raddr (rd_addr),
        .rdata (row_data)
    );

    // ------------------------------------------------------------------------
    // Basis bookkeeping
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else if (in_fire && (opcode == OP_CLEAR))
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else if (row_we)
        begin
            occ_reg[bit_reg] <= 1'b1;
            count_reg        <= count_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= opcode;
            v_reg      <= is_reduce_op ? in_masked : '0;
            bit_reg    <= AW'(w_eff - WIDTH_W'(1));
            pivot_reg  <= '0;
            span_reg   <= is_reduce_op;
            stored_reg <= 1'b0;
        end
        else if (ctrl.scan)
        begin
            if (cur_set && !cur_occ)
            begin
                // Free pivot: the scan stops with the vector as reduced so far.
                span_reg   <= 1'b0;
                pivot_reg  <= bit_reg;
                stored_reg <= (op_reg == OP_INSERT);
            end
            else
            begin
                if (cur_set)
                begin
                    v_reg <= v_reg ^ row_data;
                end
                bit_reg <= bit_reg - AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.deliver)
        begin
            in_span_reg    <= span_reg;
            stored_out_reg <= stored_reg;
            pivot_out_reg  <= PIVOT_W'(pivot_reg);
            residue_reg    <= VEC_W'(v_reg);
            rank_reg       <= RANK_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_span     = in_span_reg;
    assign stored      = stored_out_reg;
    assign pivot_index = pivot_out_reg;
    assign residue     = residue_reg;
    assign rank        = rank_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_CLK(a_rank_matches_mask, clk, rst_n, count_reg == CNT_W'($countones(occ_reg)), "rank differs from occupied pivot count")
    `ASSERT_NEVER(a_write_free_pivot, clk, rst_n, row_we && occ_reg[bit_reg], "row written over an occupied pivot")
    `ASSERT_CLK(a_deliver_sets_valid, clk, rst_n, ctrl.deliver |=> out_valid_reg, "result not presented after delivery")
    `ASSERT_NEVER(a_stored_not_span, clk, rst_n, out_valid_reg && stored_out_reg && in_span_reg, "result both stored and in span")

endmodule

// ===== rtl/gxb_row_mem.sv =====
// ============================================================================
// gxb_row_mem
// Basis row storage: one write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps

module gxb_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gxb_seq.sv =====
// ============================================================================
// gxb_seq
// Sequencer for the basis engine: accept, bit-serial scan, result hand-off.
// ============================================================================
`timescale 1ns / 1ps

module gxb_seq
    import gxb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gxb_status_t status,
    output gxb_ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_fire)
                begin
                    state_next = status.need_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.idle = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.deliver = status.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule
